// ===== hw/rtl/eldt_pkg.sv =====
// ----------------------------------------------------------------------------
// eldt_pkg
// Shared types, codes and sizes for the event listener dispatch table.
// ----------------------------------------------------------------------------
`default_nettype none

package eldt_pkg;

  // Default table depth and cap on calls per dispatch
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int NW              = $clog2(MAX_RESULTS + 1);

  // Stream and register port widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  // Operation codes
  localparam logic [2:0] ACT_ADD      = 3'd0;
  localparam logic [2:0] ACT_REMOVE   = 3'd1;
  localparam logic [2:0] ACT_SET_EN   = 3'd2;
  localparam logic [2:0] ACT_QUERY    = 3'd3;
  localparam logic [2:0] ACT_DISPATCH = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_STATUS    = 2'd0;
  localparam logic [1:0] KIND_CALL      = 2'd1;
  localparam logic [1:0] KIND_DEFAULT   = 2'd2;
  localparam logic [1:0] KIND_UNHANDLED = 2'd3;

  // Register indexes
  localparam logic REG_DEFAULT_HANDLER = 1'b0;
  localparam logic REG_DEFAULT_ENABLED = 1'b1;

  // One listener entry as stored in the table memory
  typedef struct packed {
    logic       en;
    logic [7:0] handler;
    logic [7:0] code;
  } entry_t;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic [7:0] default_handler;
    logic       default_enabled;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/eldt_table.sv =====
// ----------------------------------------------------------------------------
// eldt_table
// Listener table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module eldt_table #(
  parameter int DEPTH = eldt_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic [AW-1:0]   rd_addr,
  output eldt_pkg::entry_t     rd_data,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire eldt_pkg::entry_t wr_data
);
  import eldt_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/eldt_cfg.sv =====
// ----------------------------------------------------------------------------
// eldt_cfg
// Register port: default handler id and default enable.
// ----------------------------------------------------------------------------
`default_nettype none

module eldt_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [eldt_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [eldt_pkg::CFG_DW-1:0]   pwdata,
  output logic      [eldt_pkg::CFG_DW-1:0]   prdata,
  output logic                               pready,
  output eldt_pkg::cfg_t                     cfg
);
  import eldt_pkg::*;

  logic [7:0] default_handler_r;
  logic       default_enabled_r;
  logic       wr_hit;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_hit  = psel && penable && pwrite && pready;

  // Take a write transfer in the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_handler_r <= '0;
      default_enabled_r <= 1'b0;
    end else if (wr_hit) begin
      case (reg_sel)
        REG_DEFAULT_HANDLER: default_handler_r <= pwdata[7:0];
        REG_DEFAULT_ENABLED: default_enabled_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_DEFAULT_HANDLER: prdata = {{(CFG_DW-8){1'b0}}, default_handler_r};
      REG_DEFAULT_ENABLED: prdata = {{(CFG_DW-1){1'b0}}, default_enabled_r};
      default: prdata = '0;
    endcase
  end

  assign cfg = '{default_handler: default_handler_r, default_enabled: default_enabled_r};

endmodule

`default_nettype wire

// ===== hw/rtl/eldt_seq.sv =====
// ----------------------------------------------------------------------------
// eldt_seq
// Operation sequencer: scans the table one entry per cycle while the result
// stream does not stall it, edits it in place, and drives the result stream through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module eldt_seq #(
  parameter int DEPTH = eldt_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [eldt_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [eldt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic      [1:0]                        out_tuser,
  output logic                                   out_tlast,
  input  wire eldt_pkg::cfg_t                    cfg,
  output logic      [AW-1:0]                     rd_addr,
  input  wire eldt_pkg::entry_t                  rd_data,
  output logic                                   wr_en,
  output logic      [AW-1:0]                     wr_addr,
  output eldt_pkg::entry_t                       wr_data
);
  import eldt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t state_r, state_nxt;

  // Item being worked on
  logic [2:0]  act_r, act_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [7:0]  hid_r, hid_nxt;
  logic        en_r, en_nxt;
  logic [15:0] param_r, param_nxt;

  // Scan state
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] idx_m1;
  logic          found_r, found_nxt;
  logic          ok_r, ok_nxt;
  logic          res_r, res_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic          pend_vld_r, pend_vld_nxt;
  logic [7:0]    pend_h_r, pend_h_nxt;

  // Output register
  logic        out_vld_r, out_vld_nxt;
  logic [1:0]  out_kind_r;
  logic        out_ok_r;
  logic [7:0]  out_h_r;
  logic [7:0]  out_code_r;
  logic [15:0] out_param_r;
  logic        out_last_r;

  // Result offered this cycle
  logic        push;
  logic [1:0]  p_kind;
  logic        p_ok;
  logic [7:0]  p_h;
  logic [7:0]  p_code;
  logic [15:0] p_param;
  logic        p_last;

  logic at_end;
  logic code_hit;
  logic pair_hit;
  logic call_hit;
  logic slot_free;

  assign at_end    = (idx_r == cnt_r);
  assign code_hit  = (rd_data.code == code_r);
  assign pair_hit  = code_hit && (rd_data.handler == hid_r);
  assign call_hit  = (rd_data.handler != 8'd0) && code_hit && rd_data.en &&
                     (n_r < NW'(MAX_RESULTS));
  assign slot_free = !out_vld_r || out_tready;
  assign idx_m1    = idx_r - CW'(1);

  assign in_tready = (state_r == S_IDLE);

  // Next state, table edits and result selection
  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    code_nxt     = code_r;
    hid_nxt      = hid_r;
    en_nxt       = en_r;
    param_nxt    = param_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    found_nxt    = found_r;
    ok_nxt       = ok_r;
    res_nxt      = res_r;
    n_nxt        = n_r;
    pend_vld_nxt = pend_vld_r;
    pend_h_nxt   = pend_h_r;

    wr_en   = 1'b0;
    wr_addr = idx_r[AW-1:0];
    wr_data = rd_data;

    push    = 1'b0;
    p_kind  = KIND_STATUS;
    p_ok    = 1'b0;
    p_h     = 8'd0;
    p_code  = 8'd0;
    p_param = 16'd0;
    p_last  = 1'b0;

    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (in_tvalid) begin
          act_nxt      = in_tdata[2:0];
          code_nxt     = in_tdata[10:3];
          hid_nxt      = in_tdata[18:11];
          en_nxt       = in_tdata[20];
          param_nxt    = in_tdata[36:21];
          found_nxt    = 1'b0;
          ok_nxt       = 1'b0;
          res_nxt      = 1'b0;
          n_nxt        = '0;
          pend_vld_nxt = 1'b0;
          case (in_tdata[2:0])
            ACT_ADD: begin
              // Null handler fails at once; plain append needs no scan
              if (in_tdata[18:11] == 8'd0) begin
                res_nxt   = 1'b1;
                state_nxt = S_DONE;
              end else if (in_tdata[19]) begin
                state_nxt = S_SCAN;
              end else begin
                state_nxt = S_DONE;
              end
            end
            ACT_REMOVE, ACT_SET_EN, ACT_QUERY, ACT_DISPATCH: begin
              state_nxt = S_SCAN;
            end
            default: begin
              res_nxt   = 1'b1;
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        case (act_r)
          ACT_ADD: begin
            // Overwrite the first entry with this code
            if (at_end) begin
              state_nxt = S_DONE;
            end else if (code_hit) begin
              wr_en     = 1'b1;
              wr_data   = '{en: 1'b1, handler: hid_r, code: code_r};
              ok_nxt    = 1'b1;
              res_nxt   = 1'b1;
              state_nxt = S_DONE;
            end else begin
              idx_nxt = idx_r + CW'(1);
            end
          end
          ACT_REMOVE: begin
            // After the match, copy each later entry one place down
            if (at_end) begin
              if (found_r) begin
                cnt_nxt = cnt_r - CW'(1);
                ok_nxt  = 1'b1;
              end
              state_nxt = S_DONE;
            end else begin
              if (found_r) begin
                wr_en   = 1'b1;
                wr_addr = idx_m1[AW-1:0];
                wr_data = rd_data;
              end else if (pair_hit) begin
                found_nxt = 1'b1;
              end
              idx_nxt = idx_r + CW'(1);
            end
          end
          ACT_SET_EN: begin
            if (at_end) begin
              state_nxt = S_DONE;
            end else if (pair_hit) begin
              wr_en     = 1'b1;
              wr_data   = '{en: en_r, handler: rd_data.handler, code: rd_data.code};
              ok_nxt    = 1'b1;
              state_nxt = S_DONE;
            end else begin
              idx_nxt = idx_r + CW'(1);
            end
          end
          ACT_QUERY: begin
            if (at_end) begin
              state_nxt = S_DONE;
            end else if (pair_hit) begin
              ok_nxt    = rd_data.en;
              state_nxt = S_DONE;
            end else begin
              idx_nxt = idx_r + CW'(1);
            end
          end
          ACT_DISPATCH: begin
            // Hold one call back until the next match or the end shows
            // whether it is the last one
            if (at_end) begin
              state_nxt = S_DONE;
            end else if (call_hit) begin
              if (!pend_vld_r || slot_free) begin
                if (pend_vld_r) begin
                  push    = 1'b1;
                  p_kind  = KIND_CALL;
                  p_h     = pend_h_r;
                  p_code  = code_r;
                  p_param = param_r;
                end
                pend_vld_nxt = 1'b1;
                pend_h_nxt   = rd_data.handler;
                n_nxt        = n_r + NW'(1);
                idx_nxt      = idx_r + CW'(1);
              end
            end else begin
              idx_nxt = idx_r + CW'(1);
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_DONE: begin
        if (slot_free) begin
          push      = 1'b1;
          p_last    = 1'b1;
          state_nxt = S_IDLE;
          case (act_r)
            ACT_DISPATCH: begin
              p_code       = code_r;
              p_param      = param_r;
              pend_vld_nxt = 1'b0;
              if (pend_vld_r) begin
                p_kind = KIND_CALL;
                p_h    = pend_h_r;
              end else if (cfg.default_handler != 8'd0 && cfg.default_enabled) begin
                p_kind = KIND_DEFAULT;
                p_h    = cfg.default_handler;
              end else begin
                p_kind = KIND_UNHANDLED;
              end
            end
            ACT_ADD: begin
              p_ok = ok_r;
              // Append at the tail when nothing was replaced, the handler is not null and room is left
              if (!res_r && (cnt_r < CW'(DEPTH))) begin
                wr_en   = 1'b1;
                wr_addr = cnt_r[AW-1:0];
                wr_data = '{en: 1'b1, handler: hid_r, code: code_r};
                cnt_nxt = cnt_r + CW'(1);
                p_ok    = 1'b1;
              end
            end
            default: begin
              p_ok = ok_r;
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Output register: load on push, drop after the transfer
    out_vld_nxt = out_vld_r;
    if (push) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Read the entry the scan will look at next cycle; a stalled scan
  // rereads the same entry
  assign rd_addr = idx_nxt[AW-1:0];

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      out_vld_r  <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  // Item, scan and result payload
  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    code_r   <= code_nxt;
    hid_r    <= hid_nxt;
    en_r     <= en_nxt;
    param_r  <= param_nxt;
    idx_r    <= idx_nxt;
    found_r  <= found_nxt;
    ok_r     <= ok_nxt;
    res_r    <= res_nxt;
    n_r      <= n_nxt;
    pend_h_r <= pend_h_nxt;
    if (push) begin
      out_kind_r  <= p_kind;
      out_ok_r    <= p_ok;
      out_h_r     <= p_h;
      out_code_r  <= p_code;
      out_param_r <= p_param;
      out_last_r  <= p_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_param_r, out_code_r, out_h_r, out_ok_r};

`ifndef SYNTH
  // Entry count never passes the table depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above table depth");

  // The table is only edited while an operation is in progress
  a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r != S_IDLE))
    else $error("table write while idle");

  // Entry count holds while idle
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> (cnt_r == $past(cnt_r)))
    else $error("entry count changed while idle");

  // No call is held back between operations
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_vld_r)
    else $error("pending call left over");

  // A status result always closes its operation
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_kind_r == KIND_STATUS)) |-> out_last_r)
    else $error("status result without last");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/event_listener_dispatch_table.sv =====
// Operations: a table scan covers the live entries; add without overwrite,
// add with a null handler and undefined actions skip the scan; a match can end
// a scan early. The table memory is scanned one entry per cycle unless a dispatch
// is stalled, and a new item is accepted only after the final result of the last
// one enters the output register; result backpressure stalls dispatch and final results.
// Reset: entry count, valid flags and configuration registers go to zero; the table itself is not cleared.
// ----------------------------------------------------------------------------
// event_listener_dispatch_table
// Ordered listener table with add, remove, enable, query and event dispatch.
// ----------------------------------------------------------------------------
`default_nettype none

module event_listener_dispatch_table #(
  parameter int TABLE_DEPTH = eldt_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // action[2:0], event_code[10:3], handler_id[18:11], overwrite[19],
  // enable_value[20], event_param[36:21], zero fill [39:37]
  input  wire logic [eldt_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // ok[0], call_handler[8:1], call_code[16:9], call_param[32:17],
  // zero fill [39:33]
  output logic      [eldt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // result_kind[1:0]
  output logic      [1:0]                        out_tuser,
  output logic                                   out_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [eldt_pkg::CFG_AW-1:0]       cfg_paddr,
  input  wire logic [eldt_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic      [eldt_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                                   cfg_pready
);
  import eldt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  cfg_t          cfg;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  eldt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  eldt_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  eldt_seq #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg        (cfg),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

endmodule

`default_nettype wire

// ===== bench/event_listener_dispatch_table_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// event_listener_dispatch_table_test
// Self-checking bench: drives table operations over the input stream and
// APB register writes, predicts every result from its own copy of the
// listener table and compares each result transfer against that prediction.
// ----------------------------------------------------------------------------

module event_listener_dispatch_table_test;
  import eldt_pkg::*;

  localparam int DEPTH           = TABLE_DEPTH_DEF;
  localparam int SETTLE_CYCLES   = DEPTH + 8;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int ITEMS_PER_PHASE = 60;
  localparam int PRINT_CAP       = 40;
  localparam int GAP_MAX         = 18;

  // Action codes the block does not define
  localparam logic [2:0] ACT_FIRST_UNUSED = ACT_DISPATCH + 3'd1;
  localparam logic [2:0] ACT_LAST_UNUSED  = 3'd7;

  typedef struct packed {
    logic [2:0]         action;
    logic [7:0]         code;
    logic [7:0]         handler;
    logic               overwrite;
    logic               enable;
    logic signed [15:0] param;
  } table_op_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        ok;
    logic [7:0]  handler;
    logic [7:0]  code;
    logic [15:0] param;
    logic        last;
  } table_result_t;

  // Shadow of the listener table and the results it must produce
  class listener_table_model;
    logic [7:0]    code_at[DEPTH];
    logic [7:0]    handler_at[DEPTH];
    logic          en_at[DEPTH];
    int            count;
    logic [7:0]    dflt_handler;
    logic          dflt_en;
    table_result_t expected_q[$];
    int            errors;

    function new();
      count        = 0;
      dflt_handler = '0;
      dflt_en      = 1'b0;
      errors       = 0;
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("mismatch: %s", msg);
      errors++;
    endtask

    function void set_reg(logic idx, logic [7:0] value);
      if (idx == REG_DEFAULT_HANDLER) dflt_handler = value;
      else dflt_en = value[0];
    endfunction

    function int find_pair(logic [7:0] c, logic [7:0] h);
      int i;
      for (i = 0; i < count; i++)
        if (code_at[i] == c && handler_at[i] == h) return i;
      return count;
    endfunction

    function int find_code(logic [7:0] c);
      int i;
      for (i = 0; i < count; i++)
        if (code_at[i] == c) return i;
      return count;
    endfunction

    function bit hits(int i, logic [7:0] c);
      return handler_at[i] != 0 && code_at[i] == c && en_at[i];
    endfunction

    function void push(logic [1:0] kind, logic ok, logic [7:0] h, logic [7:0] c,
                       logic [15:0] p, logic last);
      table_result_t r;
      r.kind = kind; r.ok = ok; r.handler = h; r.code = c; r.param = p; r.last = last;
      expected_q.push_back(r);
    endfunction

    // Apply one accepted operation and queue the results it causes
    function void note_op(table_op_t op);
      int  k, i, total, n;
      logic ok;
      ok = 1'b0;
      case (op.action)
        ACT_ADD: begin
          if (op.handler != 0) begin
            if (op.overwrite) begin
              k = find_code(op.code);
              if (k < count) begin
                handler_at[k] = op.handler;
                en_at[k]      = 1'b1;
                ok            = 1'b1;
              end
            end
            if (!ok && count < DEPTH) begin
              code_at[count]    = op.code;
              handler_at[count] = op.handler;
              en_at[count]      = 1'b1;
              count++;
              ok = 1'b1;
            end
          end
        end
        ACT_REMOVE: begin
          k = find_pair(op.code, op.handler);
          if (k < count) begin
            // close the gap, keep order
            for (i = k; i + 1 < count; i++) begin
              code_at[i]    = code_at[i + 1];
              handler_at[i] = handler_at[i + 1];
              en_at[i]      = en_at[i + 1];
            end
            count--;
            ok = 1'b1;
          end
        end
        ACT_SET_EN: begin
          k = find_pair(op.code, op.handler);
          if (k < count) begin
            en_at[k] = op.enable;
            ok       = 1'b1;
          end
        end
        ACT_QUERY: begin
          k  = find_pair(op.code, op.handler);
          ok = (k < count) && en_at[k];
        end
        ACT_DISPATCH: begin
          total = 0;
          for (i = 0; i < count; i++)
            if (hits(i, op.code) && total < MAX_RESULTS) total++;
          if (total == 0) begin
            if (dflt_handler != 0 && dflt_en)
              push(KIND_DEFAULT, 1'b0, dflt_handler, op.code, op.param, 1'b1);
            else
              push(KIND_UNHANDLED, 1'b0, 8'h00, op.code, op.param, 1'b1);
          end else begin
            n = 0;
            for (i = 0; i < count; i++) begin
              if (hits(i, op.code) && n < total) begin
                n++;
                push(KIND_CALL, 1'b0, handler_at[i], op.code, op.param, n == total);
              end
            end
          end
          return;
        end
        default: ok = 1'b0;
      endcase
      push(KIND_STATUS, ok, 8'h00, 8'h00, 16'h0000, 1'b1);
    endfunction

    // Compare one result transfer with the oldest prediction
    task check_result(table_result_t got);
      table_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d handler %02h code %02h",
                         got.kind, got.handler, got.code));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind != want.kind || got.ok != want.ok || got.handler != want.handler ||
          got.code != want.code || got.param != want.param || got.last != want.last)
        report({$sformatf("got k%0d ok%0d h%02h c%02h p%04h l%0d, ",
                          got.kind, got.ok, got.handler, got.code, got.param, got.last),
                $sformatf("want k%0d ok%0d h%02h c%02h p%04h l%0d",
                          want.kind, want.ok, want.handler, want.code, want.param,
                          want.last)});
    endtask

    // Pick a live entry so lookups hit the table
    function bit pick_entry(output logic [7:0] c, output logic [7:0] h);
      int i;
      if (count == 0) return 1'b0;
      i = $urandom_range(0, count - 1);
      c = code_at[i];
      h = handler_at[i];
      return 1'b1;
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_AW-1:0]      cfg_paddr;
  logic [CFG_DW-1:0]      cfg_pwdata;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  listener_table_model sb;
  logic [7:0]          code_pool[4];
  int                  calm_in  = 0;
  int                  calm_out = 0;
  int                  cycles   = 0;

  event_listener_dispatch_table i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Idle gap per item, with occasional stretches of back-to-back traffic
  function automatic int next_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 30);
    return $urandom_range(0, GAP_MAX);
  endfunction

  function automatic table_op_t make_op(logic [2:0] action, logic [7:0] code,
                                        logic [7:0] handler, logic overwrite,
                                        logic enable, logic [15:0] param);
    table_op_t op;
    op.action = action; op.code = code; op.handler = handler;
    op.overwrite = overwrite; op.enable = enable; op.param = param;
    return op;
  endfunction

  // Mostly well-formed traffic: lookups aimed at live entries, codes that collide
  function automatic table_op_t random_op();
    table_op_t  op;
    int         r;
    logic [7:0] c, h;
    r = $urandom_range(0, 99);
    op.code      = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                               : code_pool[$urandom_range(0, 3)];
    op.handler   = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 3));
    op.overwrite = ($urandom_range(0, 2) == 0);
    op.enable    = 1'($urandom_range(0, 1));
    op.param     = 16'($urandom);
    if (r < 28)      op.action = ACT_ADD;
    else if (r < 44) op.action = ACT_REMOVE;
    else if (r < 58) op.action = ACT_SET_EN;
    else if (r < 68) op.action = ACT_QUERY;
    else if (r < 95) op.action = ACT_DISPATCH;
    else op.action = 3'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
    if (op.action inside {ACT_REMOVE, ACT_SET_EN, ACT_QUERY, ACT_DISPATCH} &&
        $urandom_range(0, 3) != 0 && sb.pick_entry(c, h)) begin
      op.code = c;
      if (op.action != ACT_DISPATCH) op.handler = h;
    end
    return op;
  endfunction

  // Send one operation and record it once the transfer happens
  task automatic send_op(table_op_t op);
    int gap;
    gap = next_gap(calm_in);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {3'b000, op.param, op.enable, op.overwrite, op.handler, op.code, op.action};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_op(op);
  endtask

  // Hold off until every predicted result has come out, then let the block go idle
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register
  task automatic write_reg(logic idx, logic [7:0] value);
    logic [CFG_DW-1:0] readback_want;
    readback_want = (idx == REG_DEFAULT_HANDLER) ? CFG_DW'(value) : CFG_DW'(value[0]);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, value);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata != readback_want)
      sb.report($sformatf("register %0d read %08h, want %08h", idx, cfg_prdata, readback_want));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: random backpressure between transfers
  initial begin
    int gap;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      gap = next_gap(calm_out);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    table_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind    = out_tuser;
      got.ok      = out_tdata[0];
      got.handler = out_tdata[8:1];
      got.code    = out_tdata[16:9];
      got.param   = out_tdata[32:17];
      got.last    = out_tlast;
      sb.check_result(got);
    end
  end

  initial begin
    int i, p, j;
    sb = new();
    rst_n       <= 1'b0;
    in_tdata    <= '0;
    in_tvalid   <= 1'b0;
    out_tready  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, null handler, fill to full, dispatch to every entry
    send_op(make_op(ACT_DISPATCH, 8'h00, 8'h00, 1'b0, 1'b0, 16'h8000));
    send_op(make_op(ACT_ADD, 8'h5A, 8'h00, 1'b0, 1'b1, 16'h0000));
    for (i = 0; i < DEPTH; i++)
      send_op(make_op(ACT_ADD, 8'hFF, (i == DEPTH - 1) ? 8'hFF : 8'(i + 1),
                      1'b0, 1'b0, 16'h0000));
    send_op(make_op(ACT_ADD, 8'h01, 8'h01, 1'b0, 1'b1, 16'h0000));
    send_op(make_op(ACT_DISPATCH, 8'hFF, 8'h00, 1'b0, 1'b0, 16'h7FFF));
    // overwrite, disable, lookups that miss, remove with shift, undefined actions
    send_op(make_op(ACT_ADD, 8'hFF, 8'h80, 1'b1, 1'b0, 16'h0000));
    send_op(make_op(ACT_SET_EN, 8'hFF, 8'h80, 1'b0, 1'b0, 16'h0000));
    send_op(make_op(ACT_QUERY, 8'hFF, 8'h80, 1'b0, 1'b0, 16'h0000));
    send_op(make_op(ACT_QUERY, 8'h00, 8'h03, 1'b0, 1'b0, 16'h0000));
    send_op(make_op(ACT_REMOVE, 8'hFF, 8'h02, 1'b0, 1'b0, 16'h0000));
    send_op(make_op(ACT_REMOVE, 8'hFF, 8'h02, 1'b0, 1'b0, 16'h0000));
    send_op(make_op(ACT_SET_EN, 8'h00, 8'h01, 1'b0, 1'b1, 16'h0000));
    send_op(make_op(ACT_QUERY, 8'hFF, 8'h03, 1'b1, 1'b1, 16'hFFFF));
    send_op(make_op(ACT_FIRST_UNUSED, 8'hFF, 8'hFF, 1'b1, 1'b1, 16'hFFFF));
    send_op(make_op(ACT_LAST_UNUSED, 8'hFF, 8'hFF, 1'b1, 1'b1, 16'hFFFF));
    settle();

    // Random phases, each under its own default-handler setting
    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin
          write_reg(REG_DEFAULT_HANDLER, 8'hFF);
          write_reg(REG_DEFAULT_ENABLED, 8'h01);
        end
        1: begin
          write_reg(REG_DEFAULT_HANDLER, 8'h00);
          write_reg(REG_DEFAULT_ENABLED, 8'h01);
        end
        2: begin
          write_reg(REG_DEFAULT_HANDLER, 8'($urandom_range(1, 254)));
          write_reg(REG_DEFAULT_ENABLED, 8'h00);
        end
        default: begin
          write_reg(REG_DEFAULT_HANDLER, 8'($urandom_range(1, 254)));
          write_reg(REG_DEFAULT_ENABLED, 8'h01);
        end
      endcase
      for (j = 0; j < 4; j++) code_pool[j] = 8'($urandom);
      if (p == 0) code_pool[0] = 8'hFF;
      repeat (ITEMS_PER_PHASE) send_op(random_op());
      settle();
    end

    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/eldt_pkg.sv
hw/rtl/eldt_table.sv
hw/rtl/eldt_cfg.sv
hw/rtl/eldt_seq.sv
hw/rtl/event_listener_dispatch_table.sv
bench/event_listener_dispatch_table_test.sv
